@@ sv/rbi_pkg.sv @@
// ----------------------------------------------------------------------------
// rbi_pkg
// Shared constants and types of the ray versus box intersection block.
// ----------------------------------------------------------------------------
package rbi_pkg;

   localparam int DIR_WIDTH = 18;
   localparam int LEN_WIDTH = 31;
   localparam int FRAC_BITS = 16;
   localparam int NUM_AXES  = 3;
   // Quotient bits resolved by each divider stage.
   localparam int DIV_STEPS = 4;
   // Face distances saturate at two to this power.
   localparam int T_SAT_EXP = 56;
   localparam int T_WIDTH   = T_SAT_EXP + 2;

   localparam logic ACTION_BOOL  = 1'b0;
   localparam logic ACTION_POINT = 1'b1;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOX_MIN_X = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOX_MIN_Y = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOX_MIN_Z = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOX_MAX_X = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOX_MAX_Y = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOX_MAX_Z = 3'd5;

   typedef struct packed {
      logic       action;
      logic       start_in;
      logic       end_in;
      logic [2:0] dir_zero;
      logic [2:0] t_neg;
   } flags_type;

endpackage

@@ sv/ray_box_intersection_top.sv @@
// ----------------------------------------------------------------------------
// ray_box_intersection_top
// Ray segment versus axis-aligned box test, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// The box corners are written through the csr_ port, one register per write;
// the user must write them only while no word is in flight, which the block
// does not enforce. Each req_ word carries a segment (start, end, unit
// direction, length) and a mode bit; each rsp_ word returns the hit flag and,
// in point mode, the hit point. One word is accepted per cycle unless a stall
// on rsp_ready has filled the pipeline. It holds one setup stage, the face
// distance divider that resolves four quotient bits per stage, and three
// stages for the face choice, the hit point multiply and the final box check.
// Every stage has its own valid bit and moves when its successor is empty or
// moving, so under a stall on rsp_ready the pipeline keeps taking words until
// it is full; nothing is dropped or repeated.
// Reset clears all valid bits and the box registers to zero.
// ----------------------------------------------------------------------------
module ray_box_intersection_top #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_action,
   input  logic signed [COORD_WIDTH-1:0]           req_ray_start_x,
   input  logic signed [COORD_WIDTH-1:0]           req_ray_start_y,
   input  logic signed [COORD_WIDTH-1:0]           req_ray_start_z,
   input  logic signed [COORD_WIDTH-1:0]           req_ray_end_x,
   input  logic signed [COORD_WIDTH-1:0]           req_ray_end_y,
   input  logic signed [COORD_WIDTH-1:0]           req_ray_end_z,
   input  logic signed [rbi_pkg::DIR_WIDTH-1:0]    req_dir_x,
   input  logic signed [rbi_pkg::DIR_WIDTH-1:0]    req_dir_y,
   input  logic signed [rbi_pkg::DIR_WIDTH-1:0]    req_dir_z,
   input  logic [rbi_pkg::LEN_WIDTH-1:0]           req_ray_length,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_hit,
   output logic signed [COORD_WIDTH-1:0]           rsp_hit_x,
   output logic signed [COORD_WIDTH-1:0]           rsp_hit_y,
   output logic signed [COORD_WIDTH-1:0]           rsp_hit_z,
   input  logic                                    csr_write_enable,
   input  logic [rbi_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [COORD_WIDTH-1:0]                  csr_data
);

   localparam int CW = COORD_WIDTH;
   localparam int DW = rbi_pkg::DIR_WIDTH;
   localparam int LW = rbi_pkg::LEN_WIDTH;
   localparam int QW = CW + 1 + rbi_pkg::FRAC_BITS;

   logic [CW-1:0] box_lo_ff [3];
   logic [CW-1:0] box_hi_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            box_lo_ff[i] <= '0;
            box_hi_ff[i] <= '0;
         end
      end else if (csr_write_enable) begin
         case (csr_index)
            rbi_pkg::CSR_BOX_MIN_X: box_lo_ff[0] <= csr_data;
            rbi_pkg::CSR_BOX_MIN_Y: box_lo_ff[1] <= csr_data;
            rbi_pkg::CSR_BOX_MIN_Z: box_lo_ff[2] <= csr_data;
            rbi_pkg::CSR_BOX_MAX_X: box_hi_ff[0] <= csr_data;
            rbi_pkg::CSR_BOX_MAX_Y: box_hi_ff[1] <= csr_data;
            rbi_pkg::CSR_BOX_MAX_Z: box_hi_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   logic [CW-1:0] ray_s [3];
   logic [CW-1:0] ray_e [3];
   logic [DW-1:0] ray_d [3];

   assign ray_s[0] = req_ray_start_x;
   assign ray_s[1] = req_ray_start_y;
   assign ray_s[2] = req_ray_start_z;
   assign ray_e[0] = req_ray_end_x;
   assign ray_e[1] = req_ray_end_y;
   assign ray_e[2] = req_ray_end_z;
   assign ray_d[0] = req_dir_x;
   assign ray_d[1] = req_dir_y;
   assign ray_d[2] = req_dir_z;

   logic               su_valid, su_ready;
   rbi_pkg::flags_type su_flags;
   logic [CW-1:0]      su_s [3];
   logic [DW-1:0]      su_d [3];
   logic [LW-1:0]      su_len;
   logic [CW-1:0]      su_face [3];
   logic [CW:0]        su_nm [3];
   logic [DW-1:0]      su_dm [3];

   rbi_setup #(.CW(CW)) u_setup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .action    (req_action),
      .ray_s     (ray_s),
      .ray_e     (ray_e),
      .ray_d     (ray_d),
      .ray_len   (req_ray_length),
      .box_lo    (box_lo_ff),
      .box_hi    (box_hi_ff),
      .out_valid (su_valid),
      .out_ready (su_ready),
      .out_flags (su_flags),
      .out_s     (su_s),
      .out_d     (su_d),
      .out_len   (su_len),
      .out_face  (su_face),
      .out_nm    (su_nm),
      .out_dm    (su_dm)
   );

   logic               dv_valid, dv_ready;
   rbi_pkg::flags_type dv_flags;
   logic [CW-1:0]      dv_s [3];
   logic [DW-1:0]      dv_d [3];
   logic [LW-1:0]      dv_len;
   logic [CW-1:0]      dv_face [3];
   logic [QW-1:0]      dv_quot [3];

   rbi_div_pipe #(.CW(CW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (su_valid),
      .in_ready  (su_ready),
      .in_flags  (su_flags),
      .in_s      (su_s),
      .in_d      (su_d),
      .in_len    (su_len),
      .in_face   (su_face),
      .in_nm     (su_nm),
      .in_dm     (su_dm),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_flags (dv_flags),
      .out_s     (dv_s),
      .out_d     (dv_d),
      .out_len   (dv_len),
      .out_face  (dv_face),
      .out_quot  (dv_quot)
   );

   logic [CW-1:0] hit_pt [3];

   rbi_finish #(.CW(CW)) u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid),
      .in_ready  (dv_ready),
      .in_flags  (dv_flags),
      .in_s      (dv_s),
      .in_d      (dv_d),
      .in_len    (dv_len),
      .in_face   (dv_face),
      .in_quot   (dv_quot),
      .box_lo    (box_lo_ff),
      .box_hi    (box_hi_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_hit   (rsp_hit),
      .out_pt    (hit_pt)
   );

   assign rsp_hit_x = hit_pt[0];
   assign rsp_hit_y = hit_pt[1];
   assign rsp_hit_z = hit_pt[2];

   // A miss never carries a point.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_x == '0 && rsp_hit_y == '0 && rsp_hit_z == '0)
      else $error("miss word carries a nonzero point");

   // With the output stage empty, every stage can move, so input is open.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked while output stage is empty");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

@@ sv/rbi_setup.sv @@
// ----------------------------------------------------------------------------
// rbi_setup
// First stage: containment tests, face choice and divider operands.
// ----------------------------------------------------------------------------
module rbi_setup #(
   parameter int CW = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic                                action,
   input  logic [CW-1:0]                       ray_s [3],
   input  logic [CW-1:0]                       ray_e [3],
   input  logic [rbi_pkg::DIR_WIDTH-1:0]       ray_d [3],
   input  logic [rbi_pkg::LEN_WIDTH-1:0]       ray_len,
   input  logic [CW-1:0]                       box_lo [3],
   input  logic [CW-1:0]                       box_hi [3],
   output logic                                out_valid,
   input  logic                                out_ready,
   output rbi_pkg::flags_type                  out_flags,
   output logic [CW-1:0]                       out_s [3],
   output logic [rbi_pkg::DIR_WIDTH-1:0]       out_d [3],
   output logic [rbi_pkg::LEN_WIDTH-1:0]       out_len,
   output logic [CW-1:0]                       out_face [3],
   output logic [CW:0]                         out_nm [3],
   output logic [rbi_pkg::DIR_WIDTH-1:0]       out_dm [3]
);

   localparam int DW = rbi_pkg::DIR_WIDTH;

   logic               valid_ff;
   logic               en;
   rbi_pkg::flags_type flags_in, flags_ff;
   logic [CW-1:0]      face_in [3];
   logic [CW:0]        nm_in [3];
   logic [DW-1:0]      dm_in [3];
   logic [CW-1:0]      s_ff [3];
   logic [DW-1:0]      d_ff [3];
   logic [rbi_pkg::LEN_WIDTH-1:0] len_ff;
   logic [CW-1:0]      face_ff [3];
   logic [CW:0]        nm_ff [3];
   logic [DW-1:0]      dm_ff [3];

   assign en       = !valid_ff || out_ready;
   assign in_ready = en;

   always_comb begin
      logic s_in, e_in, sel_in, dpos;
      logic [CW:0] num;
      s_in = 1'b1;
      e_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if ($signed(ray_s[i]) < $signed(box_lo[i]) || $signed(ray_s[i]) > $signed(box_hi[i]))
            s_in = 1'b0;
         if ($signed(ray_e[i]) < $signed(box_lo[i]) || $signed(ray_e[i]) > $signed(box_hi[i]))
            e_in = 1'b0;
      end
      // The slab search runs from inside only in point mode.
      sel_in = (action == rbi_pkg::ACTION_POINT) && s_in;
      flags_in.action   = action;
      flags_in.start_in = s_in;
      flags_in.end_in   = e_in;
      for (int i = 0; i < 3; i++) begin
         dpos = !ray_d[i][DW-1] && (ray_d[i] != '0);
         face_in[i] = (sel_in == dpos) ? box_hi[i] : box_lo[i];
         num = {face_in[i][CW-1], face_in[i]} - {ray_s[i][CW-1], ray_s[i]};
         nm_in[i] = num[CW] ? -num : num;
         dm_in[i] = ray_d[i][DW-1] ? -ray_d[i] : ray_d[i];
         flags_in.dir_zero[i] = (ray_d[i] == '0);
         flags_in.t_neg[i]    = num[CW] ^ ray_d[i][DW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         flags_ff <= flags_in;
         len_ff   <= ray_len;
         for (int i = 0; i < 3; i++) begin
            s_ff[i]    <= ray_s[i];
            d_ff[i]    <= ray_d[i];
            face_ff[i] <= face_in[i];
            nm_ff[i]   <= nm_in[i];
            dm_ff[i]   <= dm_in[i];
         end
      end
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_len   = len_ff;
   assign out_s     = s_ff;
   assign out_d     = d_ff;
   assign out_face  = face_ff;
   assign out_nm    = nm_ff;
   assign out_dm    = dm_ff;

endmodule

@@ sv/rbi_div_lane.sv @@
// ----------------------------------------------------------------------------
// rbi_div_lane
// Pipelined restoring divider for one axis: (nm * 2^16) / dm, a few
// quotient bits per stage.
// ----------------------------------------------------------------------------
module rbi_div_lane #(
   parameter int CW = 32
) (
   input  logic                                  clock,
   input  logic [((CW+1+rbi_pkg::FRAC_BITS)+rbi_pkg::DIV_STEPS-1)/rbi_pkg::DIV_STEPS-1:0] en,
   input  logic [CW:0]                           in_nm,
   input  logic [rbi_pkg::DIR_WIDTH-1:0]         in_dm,
   output logic [CW+rbi_pkg::FRAC_BITS:0]        out_quot
);

   localparam int QW    = CW + 1 + rbi_pkg::FRAC_BITS;
   localparam int STEPS = rbi_pkg::DIV_STEPS;
   localparam int NDIV  = (QW + STEPS - 1) / STEPS;
   localparam int RW    = rbi_pkg::DIR_WIDTH;

   // The word starts as the dividend and fills with quotient bits from the bottom.
   logic [QW-1:0] word_in [NDIV];
   logic [QW-1:0] word_ff [NDIV];
   logic [RW-1:0] rem_in [NDIV];
   logic [RW-1:0] rem_ff [NDIV];
   logic [RW-1:0] dm_in [NDIV];
   logic [RW-1:0] dm_ff [NDIV];

   always_comb begin
      logic [QW-1:0] w;
      logic [RW-1:0] r;
      logic [RW-1:0] dv;
      logic [RW:0]   sh;
      for (int k = 0; k < NDIV; k++) begin
         if (k == 0) begin
            w  = {in_nm, {rbi_pkg::FRAC_BITS{1'b0}}};
            r  = '0;
            dv = in_dm;
         end else begin
            w  = word_ff[k-1];
            r  = rem_ff[k-1];
            dv = dm_ff[k-1];
         end
         for (int j = 0; j < STEPS; j++) begin
            if (k * STEPS + j < QW) begin
               sh = {r, w[QW-1]};
               w  = {w[QW-2:0], 1'b0};
               if (sh >= {1'b0, dv}) begin
                  sh   = sh - {1'b0, dv};
                  w[0] = 1'b1;
               end
               r = sh[RW-1:0];
            end
         end
         word_in[k] = w;
         rem_in[k]  = r;
         dm_in[k]   = dv;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NDIV; k++) begin
         if (en[k]) begin
            word_ff[k] <= word_in[k];
            rem_ff[k]  <= rem_in[k];
            dm_ff[k]   <= dm_in[k];
         end
      end
   end

   assign out_quot = word_ff[NDIV-1];

endmodule

@@ sv/rbi_div_pipe.sv @@
// ----------------------------------------------------------------------------
// rbi_div_pipe
// Three divider lanes with the ray data carried alongside and per-stage
// valid bits, so bubbles close up under a stall.
// ----------------------------------------------------------------------------
module rbi_div_pipe #(
   parameter int CW = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  rbi_pkg::flags_type                  in_flags,
   input  logic [CW-1:0]                       in_s [3],
   input  logic [rbi_pkg::DIR_WIDTH-1:0]       in_d [3],
   input  logic [rbi_pkg::LEN_WIDTH-1:0]       in_len,
   input  logic [CW-1:0]                       in_face [3],
   input  logic [CW:0]                         in_nm [3],
   input  logic [rbi_pkg::DIR_WIDTH-1:0]       in_dm [3],
   output logic                                out_valid,
   input  logic                                out_ready,
   output rbi_pkg::flags_type                  out_flags,
   output logic [CW-1:0]                       out_s [3],
   output logic [rbi_pkg::DIR_WIDTH-1:0]       out_d [3],
   output logic [rbi_pkg::LEN_WIDTH-1:0]       out_len,
   output logic [CW-1:0]                       out_face [3],
   output logic [CW+rbi_pkg::FRAC_BITS:0]      out_quot [3]
);

   localparam int QW   = CW + 1 + rbi_pkg::FRAC_BITS;
   localparam int NDIV = (QW + rbi_pkg::DIV_STEPS - 1) / rbi_pkg::DIV_STEPS;
   localparam int DW   = rbi_pkg::DIR_WIDTH;

   logic [NDIV-1:0]    valid_ff;
   logic [NDIV-1:0]    en;
   rbi_pkg::flags_type flags_ff [NDIV];
   logic [CW-1:0]      s_ff [NDIV][3];
   logic [DW-1:0]      d_ff [NDIV][3];
   logic [rbi_pkg::LEN_WIDTH-1:0] len_ff [NDIV];
   logic [CW-1:0]      face_ff [NDIV][3];

   always_comb begin
      for (int k = NDIV - 1; k >= 0; k--) begin
         if (k == NDIV - 1)
            en[k] = !valid_ff[k] || out_ready;
         else
            en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NDIV; k++) begin
            if (en[k])
               valid_ff[k] <= (k == 0) ? in_valid : valid_ff[k-1];
         end
      end
      for (int k = 0; k < NDIV; k++) begin
         if (en[k]) begin
            if (k == 0) begin
               flags_ff[k] <= in_flags;
               len_ff[k]   <= in_len;
               for (int i = 0; i < 3; i++) begin
                  s_ff[k][i]    <= in_s[i];
                  d_ff[k][i]    <= in_d[i];
                  face_ff[k][i] <= in_face[i];
               end
            end else begin
               flags_ff[k] <= flags_ff[k-1];
               len_ff[k]   <= len_ff[k-1];
               for (int i = 0; i < 3; i++) begin
                  s_ff[k][i]    <= s_ff[k-1][i];
                  d_ff[k][i]    <= d_ff[k-1][i];
                  face_ff[k][i] <= face_ff[k-1][i];
               end
            end
         end
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      rbi_div_lane #(.CW(CW)) u_lane (
         .clock    (clock),
         .en       (en),
         .in_nm    (in_nm[i]),
         .in_dm    (in_dm[i]),
         .out_quot (out_quot[i])
      );
   end

   assign out_valid = valid_ff[NDIV-1];
   assign out_flags = flags_ff[NDIV-1];
   assign out_len   = len_ff[NDIV-1];
   assign out_s     = s_ff[NDIV-1];
   assign out_d     = d_ff[NDIV-1];
   assign out_face  = face_ff[NDIV-1];

endmodule

@@ sv/rbi_finish.sv @@
// ----------------------------------------------------------------------------
// rbi_finish
// Face choice and range check, hit point products, and the final box
// check feeding the output register.
// ----------------------------------------------------------------------------
module rbi_finish #(
   parameter int CW = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  rbi_pkg::flags_type                  in_flags,
   input  logic [CW-1:0]                       in_s [3],
   input  logic [rbi_pkg::DIR_WIDTH-1:0]       in_d [3],
   input  logic [rbi_pkg::LEN_WIDTH-1:0]       in_len,
   input  logic [CW-1:0]                       in_face [3],
   input  logic [CW+rbi_pkg::FRAC_BITS:0]      in_quot [3],
   input  logic [CW-1:0]                       box_lo [3],
   input  logic [CW-1:0]                       box_hi [3],
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic                                out_hit,
   output logic [CW-1:0]                       out_pt [3]
);

   localparam int QW  = CW + 1 + rbi_pkg::FRAC_BITS;
   localparam int SW  = (QW > rbi_pkg::T_SAT_EXP + 1) ? QW : rbi_pkg::T_SAT_EXP + 1;
   localparam int TW  = rbi_pkg::T_WIDTH;
   localparam int DW  = rbi_pkg::DIR_WIDTH;
   localparam int LW  = rbi_pkg::LEN_WIDTH;
   localparam int MW  = DW + LW + 1;
   localparam int PW  = ((CW > MW - rbi_pkg::FRAC_BITS) ? CW : MW - rbi_pkg::FRAC_BITS) + 1;
   localparam logic [SW-1:0] T_SAT = SW'(1) << rbi_pkg::T_SAT_EXP;

   logic va_ff, vb_ff, vc_ff;
   logic en_a, en_b, en_c;

   assign en_c     = !vc_ff || out_ready;
   assign en_b     = !vb_ff || en_c;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   // Stage A: signed face distances, pick one, range check.
   logic          ok_a_in;
   logic [1:0]    axis_a_in;
   logic [LW-1:0] t_a_in;
   logic [CW-1:0] face_a_in;

   always_comb begin
      logic [SW-1:0] q;
      logic [TW-1:0] t [3];
      logic [TW-1:0] best;
      logic          found, sel_in;
      sel_in = (in_flags.action == rbi_pkg::ACTION_POINT) && in_flags.start_in;
      for (int i = 0; i < 3; i++) begin
         q = '0;
         q[QW-1:0] = in_quot[i];
         if (q > T_SAT)
            q = T_SAT;
         t[i] = {1'b0, q[TW-2:0]};
         if (in_flags.t_neg[i])
            t[i] = -t[i];
      end
      found     = 1'b0;
      best      = '0;
      axis_a_in = 2'd0;
      for (int i = 0; i < 3; i++) begin
         if (!in_flags.dir_zero[i] &&
             (!found || (sel_in ? ($signed(t[i]) < $signed(best))
                                : ($signed(t[i]) > $signed(best))))) begin
            found     = 1'b1;
            best      = t[i];
            axis_a_in = 2'(i);
         end
      end
      ok_a_in   = found && !best[TW-1] && (best <= TW'(in_len));
      t_a_in    = best[LW-1:0];
      face_a_in = in_face[axis_a_in];
   end

   rbi_pkg::flags_type flags_a_ff, flags_b_ff;
   logic [CW-1:0] s_a_ff [3];
   logic [CW-1:0] s_b_ff [3];
   logic [DW-1:0] d_a_ff [3];
   logic          ok_a_ff, ok_b_ff;
   logic [1:0]    axis_a_ff, axis_b_ff;
   logic [LW-1:0] t_a_ff;
   logic [CW-1:0] face_a_ff, face_b_ff;
   logic [MW-1:0] prod_b_ff [3];

   // Stage C results.
   logic          hit_c_in;
   logic [CW-1:0] pt_c_in [3];
   logic          hit_c_ff;
   logic [CW-1:0] pt_c_ff [3];

   always_comb begin
      logic [PW-1:0] pt;
      logic [MW-1:0] sc;
      logic          slab_hit;
      slab_hit = ok_b_ff;
      for (int i = 0; i < 3; i++) begin
         // Arithmetic shift gives the floor of the scaled product.
         sc = MW'($signed(prod_b_ff[i]) >>> rbi_pkg::FRAC_BITS);
         pt = PW'($signed(s_b_ff[i])) + PW'($signed(sc));
         if (axis_b_ff == 2'(i)) begin
            pt_c_in[i] = face_b_ff;
         end else begin
            pt_c_in[i] = pt[CW-1:0];
            if ($signed(pt) < $signed(PW'($signed(box_lo[i]))) ||
                $signed(pt) > $signed(PW'($signed(box_hi[i]))))
               slab_hit = 1'b0;
         end
      end
      if (flags_b_ff.action == rbi_pkg::ACTION_BOOL) begin
         hit_c_in = flags_b_ff.start_in || flags_b_ff.end_in || slab_hit;
         for (int i = 0; i < 3; i++)
            pt_c_in[i] = '0;
      end else if (flags_b_ff.start_in && flags_b_ff.end_in) begin
         hit_c_in = 1'b1;
         for (int i = 0; i < 3; i++)
            pt_c_in[i] = s_b_ff[i];
      end else begin
         hit_c_in = slab_hit;
         if (!slab_hit)
            for (int i = 0; i < 3; i++)
               pt_c_in[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (en_a) va_ff <= in_valid;
         if (en_b) vb_ff <= va_ff;
         if (en_c) vc_ff <= vb_ff;
      end
      if (en_a) begin
         flags_a_ff <= in_flags;
         ok_a_ff    <= ok_a_in;
         axis_a_ff  <= axis_a_in;
         t_a_ff     <= t_a_in;
         face_a_ff  <= face_a_in;
         s_a_ff     <= in_s;
         d_a_ff     <= in_d;
      end
      if (en_b) begin
         flags_b_ff <= flags_a_ff;
         ok_b_ff    <= ok_a_ff;
         axis_b_ff  <= axis_a_ff;
         face_b_ff  <= face_a_ff;
         s_b_ff     <= s_a_ff;
         for (int i = 0; i < 3; i++)
            prod_b_ff[i] <= MW'($signed(d_a_ff[i]) * $signed({1'b0, t_a_ff}));
      end
      if (en_c) begin
         hit_c_ff <= hit_c_in;
         pt_c_ff  <= pt_c_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_hit   = hit_c_ff;
   assign out_pt    = pt_c_ff;

endmodule
